// ===== rtl/amrdf_pkg.sv =====
// ============================================================================
// amrdf_pkg
// Shared types, constants and lookup tables of the AMR storage deframer.
// ============================================================================
package amrdf_pkg;

    typedef enum logic [1:0] {
        PH_MAGIC  = 2'd0,
        PH_HEADER = 2'd1,
        PH_BODY   = 2'd2,
        PH_STOP   = 2'd3
    } phase_t;

    typedef enum logic [2:0] {
        ST_MAGIC     = 3'd0,
        ST_OK        = 3'd1,
        ST_BADMAGIC  = 3'd2,
        ST_INVALID   = 3'd3,
        ST_UNDEFINED = 3'd4,
        ST_TRUNC     = 3'd5,
        ST_ENDED     = 3'd6
    } status_t;

    localparam int unsigned TDATA_W = 56;
    localparam int unsigned TUSER_W = 2;

    localparam logic [3:0]  MAGIC_NB_POS   = 4'd5;
    localparam logic [3:0]  MAGIC_LAST_POS = 4'd8;
    localparam logic [7:0]  CHAR_LF        = 8'h0A;
    // Table entries that mark a reserved frame type.
    localparam logic [5:0]  LEN_RESERVED   = 6'd63;
    localparam logic [5:0]  LEN_UNDEFINED  = 6'd0;
    localparam logic [5:0]  LEN_HEADER_ONLY = 6'd1;
    localparam logic [31:0] SPF_NB         = 32'd160;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       stream_end;
    } in_item_t;

    typedef struct packed {
        logic        byte_valid;
        logic [7:0]  out_byte;
        logic        frame_first;
        logic        frame_last;
        logic [3:0]  frame_type;
        logic [5:0]  frame_length;
        logic [31:0] timestamp;
        logic        wideband;
        status_t     status;
    } result_t;

    // Expected magic byte at each position of "#!AMR-WB\n".
    function automatic logic [7:0] magic_char(input logic [3:0] pos);
        logic [7:0] c;
        case (pos)
            4'd0:    c = 8'h23;
            4'd1:    c = 8'h21;
            4'd2:    c = 8'h41;
            4'd3:    c = 8'h4D;
            4'd4:    c = 8'h52;
            4'd5:    c = 8'h2D;
            4'd6:    c = 8'h57;
            4'd7:    c = 8'h42;
            4'd8:    c = 8'h0A;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    // Frame length including the header byte, per frame type.
    function automatic logic [5:0] frame_len(input logic wide, input logic [3:0] ft);
        logic [5:0] n;
        if (wide) begin
            case (ft)
                4'd0:    n = 6'd18;
                4'd1:    n = 6'd24;
                4'd2:    n = 6'd33;
                4'd3:    n = 6'd37;
                4'd4:    n = 6'd41;
                4'd5:    n = 6'd47;
                4'd6:    n = 6'd51;
                4'd7:    n = 6'd59;
                4'd8:    n = 6'd61;
                4'd9:    n = 6'd6;
                4'd14:   n = 6'd1;
                4'd15:   n = 6'd1;
                default: n = LEN_UNDEFINED;
            endcase
        end else begin
            case (ft)
                4'd0:    n = 6'd13;
                4'd1:    n = 6'd14;
                4'd2:    n = 6'd16;
                4'd3:    n = 6'd18;
                4'd4:    n = 6'd20;
                4'd5:    n = 6'd21;
                4'd6:    n = 6'd27;
                4'd7:    n = 6'd32;
                4'd8:    n = 6'd6;
                4'd9:    n = LEN_RESERVED;
                4'd10:   n = LEN_RESERVED;
                4'd11:   n = LEN_RESERVED;
                4'd15:   n = 6'd1;
                default: n = LEN_UNDEFINED;
            endcase
        end
        return n;
    endfunction

endpackage

// ===== rtl/amrdf_in_stage.sv =====
// ============================================================================
// amrdf_in_stage
// Input register: holds one request until the parser can take it.
// ============================================================================
module amrdf_in_stage (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [7:0]          s_tdata,   // data_byte[7:0]
    input  logic                s_tlast,   // stream_end
    input  logic                advance,
    output logic                item_valid,
    output amrdf_pkg::in_item_t item
);
    import amrdf_pkg::*;

    logic     valid_reg;
    in_item_t item_reg;
    logic     load;

    assign s_tready   = !valid_reg || advance;
    assign load       = s_tvalid && s_tready;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (load) begin
            valid_reg <= 1'b1;
        end else if (advance) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            item_reg.data_byte  <= s_tdata;
            item_reg.stream_end <= s_tlast;
        end
    end

endmodule

// ===== rtl/amrdf_core.sv =====
// ============================================================================
// amrdf_core
// Magic matcher and frame parser: state registers and per-byte decode.
// ============================================================================
module amrdf_core (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                step,
    input  amrdf_pkg::in_item_t item,
    output amrdf_pkg::result_t  result
);
    import amrdf_pkg::*;

    phase_t      phase_reg,  phase_next;
    logic [3:0]  pos_reg,    pos_next;
    logic        wide_reg,   wide_next;
    logic [5:0]  left_reg,   left_next;
    logic [3:0]  type_reg,   type_next;
    logic [5:0]  len_reg,    len_next;
    logic [31:0] ts_reg,     ts_next;
    status_t     status_reg, status_next;

    logic [3:0]  hdr_type;
    logic [5:0]  hdr_len;
    logic        hdr_good;
    logic        magic_hit;
    logic        magic_nb_end;
    logic [5:0]  body_left;
    logic [31:0] ts_sum;

    assign hdr_type     = item.data_byte[6:3];
    assign hdr_len      = frame_len(wide_reg, hdr_type);
    assign hdr_good     = (hdr_len != LEN_RESERVED) && (hdr_len != LEN_UNDEFINED);
    assign magic_hit    = (item.data_byte == magic_char(pos_reg));
    assign magic_nb_end = (pos_reg == MAGIC_NB_POS) && (item.data_byte == CHAR_LF);
    assign body_left    = (left_reg != 6'd0) ? left_reg - 6'd1 : left_reg;
    // The timestamp advances by one frame's samples each time a frame completes.
    assign ts_sum       = ts_reg + (wide_reg ? (SPF_NB << 1) : SPF_NB);

    // Next-state logic.
    always_comb begin
        phase_next  = phase_reg;
        pos_next    = pos_reg;
        wide_next   = wide_reg;
        left_next   = left_reg;
        type_next   = type_reg;
        len_next    = len_reg;
        ts_next     = ts_reg;
        status_next = status_reg;
        if (step) begin
            case (phase_reg)
                PH_MAGIC: begin
                    if (magic_nb_end || (magic_hit && pos_reg == MAGIC_LAST_POS)) begin
                        wide_next   = !magic_nb_end;
                        status_next = ST_OK;
                        phase_next  = PH_HEADER;
                        if (item.stream_end) begin
                            status_next = ST_ENDED;
                            phase_next  = PH_STOP;
                        end
                    end else if (magic_hit) begin
                        pos_next = pos_reg + 4'd1;
                        if (item.stream_end) begin
                            status_next = ST_BADMAGIC;
                            phase_next  = PH_STOP;
                        end
                    end else begin
                        status_next = ST_BADMAGIC;
                        phase_next  = PH_STOP;
                    end
                end
                PH_HEADER: begin
                    if (hdr_len == LEN_RESERVED) begin
                        status_next = ST_INVALID;
                        phase_next  = PH_STOP;
                    end else if (hdr_len == LEN_UNDEFINED) begin
                        status_next = ST_UNDEFINED;
                        phase_next  = PH_STOP;
                    end else begin
                        type_next = hdr_type;
                        len_next  = hdr_len;
                        left_next = hdr_len - 6'd1;
                        if (hdr_len == LEN_HEADER_ONLY) begin
                            ts_next = ts_sum;
                            if (item.stream_end) begin
                                status_next = ST_ENDED;
                                phase_next  = PH_STOP;
                            end
                        end else begin
                            phase_next = PH_BODY;
                            if (item.stream_end) begin
                                status_next = ST_TRUNC;
                                phase_next  = PH_STOP;
                            end
                        end
                    end
                end
                PH_BODY: begin
                    left_next = body_left;
                    if (body_left == 6'd0) begin
                        ts_next    = ts_sum;
                        phase_next = PH_HEADER;
                        if (item.stream_end) begin
                            status_next = ST_ENDED;
                            phase_next  = PH_STOP;
                        end
                    end else if (item.stream_end) begin
                        status_next = ST_TRUNC;
                        phase_next  = PH_STOP;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Result fields for the byte being taken.
    always_comb begin
        result          = '0;
        result.wideband = wide_next;
        result.status   = status_next;
        case (phase_reg)
            PH_HEADER: begin
                if (hdr_good) begin
                    result.byte_valid   = 1'b1;
                    result.out_byte     = item.data_byte;
                    result.frame_first  = 1'b1;
                    result.frame_last   = (hdr_len == LEN_HEADER_ONLY);
                    result.frame_type   = hdr_type;
                    result.frame_length = hdr_len;
                    result.timestamp    = ts_reg;
                end
            end
            PH_BODY: begin
                result.byte_valid   = 1'b1;
                result.out_byte     = item.data_byte;
                result.frame_last   = (body_left == 6'd0);
                result.frame_type   = type_reg;
                result.frame_length = len_reg;
                result.timestamp    = ts_reg;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_MAGIC;
            pos_reg    <= 4'd0;
            wide_reg   <= 1'b0;
            left_reg   <= 6'd0;
            type_reg   <= 4'd0;
            len_reg    <= 6'd0;
            ts_reg     <= 32'd0;
            status_reg <= ST_MAGIC;
        end else begin
            phase_reg  <= phase_next;
            pos_reg    <= pos_next;
            wide_reg   <= wide_next;
            left_reg   <= left_next;
            type_reg   <= type_next;
            len_reg    <= len_next;
            ts_reg     <= ts_next;
            status_reg <= status_next;
        end
    end

endmodule

// ===== rtl/amrdf_out_stage.sv =====
// ============================================================================
// amrdf_out_stage
// Result register and packing of the result onto the master stream.
// ============================================================================
module amrdf_out_stage (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               load,
    input  amrdf_pkg::result_t                 result,
    output logic                               can_load,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // out_byte[7:0], frame_type[11:8], frame_length[17:12], timestamp[49:18],
    // wideband[50], status[53:51], zero[55:54]
    output logic [amrdf_pkg::TDATA_W-1:0]      m_tdata,
    // byte_valid[0], frame_first[1]
    output logic [amrdf_pkg::TUSER_W-1:0]      m_tuser,
    output logic                               m_tlast    // frame_last
);
    import amrdf_pkg::*;

    logic    valid_reg;
    result_t data_reg;

    assign can_load = !valid_reg || m_tready;
    assign m_tvalid = valid_reg;
    assign m_tdata  = {2'b00, 3'(data_reg.status), data_reg.wideband, data_reg.timestamp,
                       data_reg.frame_length, data_reg.frame_type, data_reg.out_byte};
    assign m_tuser  = {data_reg.frame_first, data_reg.byte_valid};
    assign m_tlast  = data_reg.frame_last;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (load) begin
            valid_reg <= 1'b1;
        end else if (m_tready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg <= result;
        end
    end

endmodule

// ===== rtl/amr_storage_deframer_unit.sv =====
// ============================================================================
// amr_storage_deframer_unit
// AMR-NB/WB storage file deframer: magic check, frame split and timestamps.
// ============================================================================
// Path: s_ input register, parser, result register, m_. Throughput: one byte
// per cycle while m_tready drains the result register; the parser state updates
// between the input register and the result register.
// Reset: aresetn (synchronous, active low) returns the parser to reading the
// magic, clears the mode, counters and status, and empties both registers.
module amr_storage_deframer_unit (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [7:0]                    s_tdata,   // data_byte[7:0]
    input  logic                          s_tlast,   // stream_end
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // out_byte[7:0], frame_type[11:8], frame_length[17:12], timestamp[49:18],
    // wideband[50], status[53:51], zero[55:54]
    output logic [amrdf_pkg::TDATA_W-1:0] m_tdata,
    // byte_valid[0], frame_first[1]
    output logic [amrdf_pkg::TUSER_W-1:0] m_tuser,
    output logic                          m_tlast    // frame_last
);
    import amrdf_pkg::*;

    logic     advance;
    logic     item_valid;
    in_item_t item;
    logic     step;
    result_t  result;

    assign step = item_valid && advance;

    amrdf_in_stage u_in (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    amrdf_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (step),
        .item    (item),
        .result  (result)
    );

    amrdf_out_stage u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (step),
        .result   (result),
        .can_load (advance),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    // A passed frame byte only appears while parsing is healthy or just ended.
    a_byte_status: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[0]) |->
            (m_tdata[53:51] == ST_OK || m_tdata[53:51] == ST_TRUNC ||
             m_tdata[53:51] == ST_ENDED))
        else $error("frame byte reported with an error status");

    // Frame marks never appear on a dropped byte.
    a_marks_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tuser[1] || m_tlast)) |-> m_tuser[0])
        else $error("frame mark on a byte that is not a frame byte");

    // A header that is also the last byte belongs to a one-byte frame.
    a_single_byte: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[1] && m_tlast) |-> (m_tdata[17:12] == LEN_HEADER_ONLY))
        else $error("first and last on a frame longer than one byte");

    // A byte taken by the parser always lands in the result register.
    a_step_lands: assert property (@(posedge aclk) disable iff (!aresetn)
        step |=> m_tvalid)
        else $error("parsed byte lost before the result register");

endmodule
